[design/eva_pkg.sv]
// ----------------------------------------------------------------------------
// eva_pkg
// Shared types and constants of the elementwise value ALU.
// ----------------------------------------------------------------------------
package eva_pkg;

   localparam int VALUE_WIDTH_DEF   = 48;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int OP_WIDTH          = 4;
   localparam int LEVEL_WIDTH       = 13;
   localparam int CSR_INDEX_WIDTH   = 3;
   localparam int RESET_LIMIT       = 1000000;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD   = 4'd0,
      OP_SUB   = 4'd1,
      OP_MUL   = 4'd2,
      OP_DIV   = 4'd3,
      OP_LT    = 4'd4,
      OP_GT    = 4'd5,
      OP_LE    = 4'd6,
      OP_GE    = 4'd7,
      OP_EQ    = 4'd8,
      OP_NE    = 4'd9,
      OP_AND   = 4'd10,
      OP_OR    = 4'd11,
      OP_CROSS = 4'd12
   } op_type;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OPCODE  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PASS    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_A   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_A   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_B   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_B   = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEVEL_A = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEVEL_B = 3'd7;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;        // capture operands, start work
      logic div_start;   // start a division from the prepared operands
      logic div_step;    // one radix-2 division step
      logic mul_step;    // one partial-product step
      logic prep_cross_b;// prepare the second cross division
      logic take_a;      // save the class of a
      logic finish;      // form result, update min and max
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic mul_done;
   } status_type;

endpackage

[design/elementwise_value_alu.sv]
// ----------------------------------------------------------------------------
// elementwise_value_alu
// Applies one configured operation to each pair of signed fixed-point values
// and reports the result with a running minimum and maximum.
//
// Input channel req_*: a pair value_a, value_b and new_set, taken when
// req_valid is high and req_stall low. Output channel rsp_*: result,
// set_min, set_max, delivered when rsp_valid is high and rsp_stall low.
// One item is in work at a time; req_stall stays high until its result
// transfers, and the next item is taken in the following cycle at the earliest.
// Add, sub, compare and logic ops are formed directly from the registered
// operands; multiply uses serial 16-bit partial products; divide and cross
// use the shared radix-2 divider, one quotient bit per cycle, and cross
// runs two divisions on it, one for a and one for b.
// Reset clears configuration to its defaults, empties the block and sets
// the running minimum and maximum to +1000000.0 and -1000000.0.
// A stalled result holds on rsp_* until taken. Configure via csr_* only
// while idle.
// ----------------------------------------------------------------------------
module elementwise_value_alu #(
   parameter int VALUE_WIDTH   = eva_pkg::VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = eva_pkg::FRACTION_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [VALUE_WIDTH-1:0]             req_value_a,
   input  logic [VALUE_WIDTH-1:0]             req_value_b,
   input  logic                               req_new_set,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [VALUE_WIDTH-1:0]             rsp_result,
   output logic [VALUE_WIDTH-1:0]             rsp_set_min,
   output logic [VALUE_WIDTH-1:0]             rsp_set_max,
   input  logic                               csr_write,
   input  logic [eva_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [VALUE_WIDTH-1:0]             csr_data
);

   eva_pkg::cmd_type             cmd;
   eva_pkg::status_type          status;
   logic [eva_pkg::OP_WIDTH-1:0] op_code;

   eva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .op_code   (op_code),
      .cmd       (cmd),
      .status    (status)
   );

   eva_datapath #(
      .VALUE_WIDTH   (VALUE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_value_a (req_value_a),
      .req_value_b (req_value_b),
      .req_new_set (req_new_set),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .op_code     (op_code),
      .rsp_result  (rsp_result),
      .rsp_set_min (rsp_set_min),
      .rsp_set_max (rsp_set_max)
   );

endmodule

[design/eva_ctrl.sv]
// ----------------------------------------------------------------------------
// eva_ctrl
// Sequencer of the elementwise value ALU: handshakes and step commands.
// ----------------------------------------------------------------------------
module eva_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [eva_pkg::OP_WIDTH-1:0] op_code,
   output eva_pkg::cmd_type            cmd,
   input  eva_pkg::status_type         status
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b0_0000_0001,
      ST_MUL   = 9'b0_0000_0010,
      ST_DIVA  = 9'b0_0000_0100,
      ST_PREPB = 9'b0_0000_1000,
      ST_DIVB  = 9'b0_0001_0000,
      ST_DIVW  = 9'b0_0010_0000,
      ST_FIN   = 9'b0_0100_0000,
      ST_OUT   = 9'b0_1000_0000,
      ST_START = 9'b1_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      take;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign take      = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cmd.load = take;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               case (op_code)
                  eva_pkg::OP_MUL:   state_in = ST_MUL;
                  eva_pkg::OP_DIV:   state_in = ST_START;
                  eva_pkg::OP_CROSS: state_in = ST_START;
                  default:           state_in = ST_FIN;
               endcase
            end
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            if (op_code == eva_pkg::OP_CROSS) state_in = ST_DIVA;
            else                              state_in = ST_DIVW;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (status.mul_done) state_in = ST_FIN;
         end
         ST_DIVA: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               cmd.take_a = 1'b1;
               state_in   = ST_PREPB;
            end
         end
         ST_PREPB: begin
            cmd.prep_cross_b = 1'b1;
            state_in         = ST_DIVB;
         end
         ST_DIVB, ST_DIVW: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

[design/eva_datapath.sv]
// ----------------------------------------------------------------------------
// eva_datapath
// Operand registers, shared radix-2 divider, serial multiplier, min and max.
// ----------------------------------------------------------------------------
module eva_datapath #(
   parameter int VALUE_WIDTH   = eva_pkg::VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = eva_pkg::FRACTION_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  eva_pkg::cmd_type               cmd,
   output eva_pkg::status_type            status,
   input  logic [VALUE_WIDTH-1:0]         req_value_a,
   input  logic [VALUE_WIDTH-1:0]         req_value_b,
   input  logic                           req_new_set,
   input  logic                           csr_write,
   input  logic [eva_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [VALUE_WIDTH-1:0]         csr_data,
   output logic [eva_pkg::OP_WIDTH-1:0]   op_code,
   output logic [VALUE_WIDTH-1:0]         rsp_result,
   output logic [VALUE_WIDTH-1:0]         rsp_set_min,
   output logic [VALUE_WIDTH-1:0]         rsp_set_max
);

   localparam int W   = VALUE_WIDTH;
   localparam int LW  = eva_pkg::LEVEL_WIDTH;
   localparam int DW  = W + 1;                 // magnitude width of differences
   localparam int NW  = (DW + LW > W + FRACTION_BITS) ? DW + LW
                                                      : W + FRACTION_BITS;
   localparam int CW  = $clog2(NW + 1);
   localparam int MW  = 2 * W;                 // product width
   localparam int MCH = 16;                    // multiplier bits per step
   localparam int MST = (W + MCH - 1) / MCH;
   localparam int MCW = $clog2(MST + 1);
   localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] ONE  = W'(1) << FRACTION_BITS;
   localparam logic [W+40:0] RST_WIDE = (W+41)'(eva_pkg::RESET_LIMIT) << FRACTION_BITS;
   localparam logic [W-1:0] RST_POS = (RST_WIDE > (W+41)'(VMAX)) ? VMAX : RST_WIDE[W-1:0];
   localparam logic [W-1:0] RST_NEG = (RST_WIDE > (W+41)'(VMAX)) ? VMIN : (~RST_POS + W'(1));

   // configuration
   logic [eva_pkg::OP_WIDTH-1:0] op_ff;
   logic pass_ff;
   logic signed [W-1:0] min_a_ff, max_a_ff, min_b_ff, max_b_ff;
   logic [LW-1:0] lev_a_ff, lev_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff    <= '0;
         pass_ff  <= 1'b0;
         min_a_ff <= '0;
         max_a_ff <= ONE;
         min_b_ff <= '0;
         max_b_ff <= ONE;
         lev_a_ff <= LW'(1);
         lev_b_ff <= LW'(1);
      end else if (csr_write) begin
         case (csr_index)
            eva_pkg::CSR_OPCODE:  op_ff    <= csr_data[eva_pkg::OP_WIDTH-1:0];
            eva_pkg::CSR_PASS:    pass_ff  <= csr_data[0];
            eva_pkg::CSR_MIN_A:   min_a_ff <= csr_data;
            eva_pkg::CSR_MAX_A:   max_a_ff <= csr_data;
            eva_pkg::CSR_MIN_B:   min_b_ff <= csr_data;
            eva_pkg::CSR_MAX_B:   max_b_ff <= csr_data;
            eva_pkg::CSR_LEVEL_A: lev_a_ff <= csr_data[LW-1:0];
            eva_pkg::CSR_LEVEL_B: lev_b_ff <= csr_data[LW-1:0];
            default: ;
         endcase
      end
   end
   assign op_code = op_ff;

   logic [LW-1:0] lev_a_eff, lev_b_eff;
   assign lev_a_eff = (lev_a_ff == '0) ? LW'(1) : lev_a_ff;
   assign lev_b_eff = (lev_b_ff == '0) ? LW'(1) : lev_b_ff;

   // operands
   logic signed [W-1:0] a_ff, b_ff;
   logic                new_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff   <= req_value_a;
         b_ff   <= req_value_b;
         new_ff <= req_new_set;
      end
   end

   logic [W-1:0] mag_a, mag_b;
   logic         neg;
   assign mag_a = a_ff[W-1] ? (~a_ff + W'(1)) : a_ff;
   assign mag_b = b_ff[W-1] ? (~b_ff + W'(1)) : b_ff;
   assign neg   = a_ff[W-1] ^ b_ff[W-1];

   // class prep: difference magnitudes and early answers
   function automatic logic [DW+LW+1:0] class_prep(input logic signed [W-1:0] v,
         input logic signed [W-1:0] lo, input logic signed [W-1:0] hi);
      logic signed [DW-1:0] d, r;
      logic [DW-1:0] dm, rm;
      logic dn, rn, early;
      d  = DW'(v) - DW'(lo);
      r  = DW'(hi) - DW'(lo);
      dn = d[DW-1];
      rn = r[DW-1];
      dm = dn ? (~d + DW'(1)) : d;
      rm = rn ? (~r + DW'(1)) : r;
      early = (rm == '0) || (dm == '0) || (dn != rn);
      // {early, full, dm(DW), pad(LW)} packed: low field zero pad, rm computed separately by range_mag
      class_prep = {early, (dm >= rm) && !early, dm, LW'(0)};
   endfunction

   function automatic logic [DW-1:0] range_mag(input logic signed [W-1:0] lo,
         input logic signed [W-1:0] hi);
      logic signed [DW-1:0] r;
      r = DW'(hi) - DW'(lo);
      range_mag = r[DW-1] ? (~r + DW'(1)) : r;
   endfunction

   // divider
   logic [NW-1:0]  num_ff;
   logic [NW-1:0]  quo_ff;
   logic [DW:0]    rem_ff;
   logic [DW-1:0]  den_ff;
   logic [CW-1:0]  cnt_ff;
   logic           early_ff, full_ff;
   logic [LW-1:0]  lev_ff;

   logic [DW+LW+1:0] prep;
   logic [DW-1:0]    rmag;
   logic [DW:0]      rem_sh;
   logic             ge;

   always_comb begin
      if (cmd.prep_cross_b) begin
         prep = class_prep(b_ff, min_b_ff, max_b_ff);
         rmag = range_mag(min_b_ff, max_b_ff);
      end else begin
         prep = class_prep(a_ff, min_a_ff, max_a_ff);
         rmag = range_mag(min_a_ff, max_a_ff);
      end
   end

   assign rem_sh = {rem_ff[DW-1:0], num_ff[NW-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};
   assign status.div_done = (cnt_ff == CW'(1)) && cmd.div_step;

   // dm * levels product (combinational, one multiply, stored into num_ff)
   logic [NW-1:0] dml;
   assign dml = NW'(prep[DW+LW-1:LW]) * NW'(cmd.prep_cross_b ? lev_b_eff : lev_a_eff);

   always_ff @(posedge clock) begin
      if (cmd.div_start || cmd.prep_cross_b) begin
         rem_ff <= '0;
         quo_ff <= '0;
         cnt_ff <= CW'(NW);
         if (op_ff == eva_pkg::OP_CROSS) begin
            num_ff   <= dml;
            den_ff   <= rmag;
            early_ff <= prep[DW+LW+1];
            full_ff  <= prep[DW+LW];
            lev_ff   <= cmd.prep_cross_b ? lev_b_eff : lev_a_eff;
         end else begin
            num_ff   <= NW'({mag_a, FRACTION_BITS'(0)});
            den_ff   <= DW'(mag_b);
            early_ff <= (mag_b == '0);
            full_ff  <= 1'b0;
            lev_ff   <= lev_ff;
         end
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[NW-2:0], 1'b0};
         quo_ff <= {quo_ff[NW-2:0], ge};
         rem_ff <= ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   // quotient including the final step's bit
   logic [NW-1:0] quo_now;
   assign quo_now = {quo_ff[NW-2:0], ge};

   // class from the finishing division
   logic [LW-1:0] cls_now;
   always_comb begin
      if (early_ff)     cls_now = LW'(1);
      else if (full_ff) cls_now = lev_ff;
      else              cls_now = quo_now[LW-1:0] + LW'(1);
   end

   logic [LW-1:0] cls_a_ff;
   logic [NW-1:0] quo_res_ff;
   always_ff @(posedge clock) begin
      if (cmd.take_a) cls_a_ff <= cls_now;
      if (status.div_done) quo_res_ff <= quo_now;
   end
   logic [LW-1:0] cls_b_ff;
   always_ff @(posedge clock) begin
      if (status.div_done) cls_b_ff <= cls_now;
   end

   // serial multiplier: MCH bits of b per step
   logic [MW-1:0]  acc_ff;
   logic [MW-1:0]  bsh_ff;
   logic [MCW-1:0] mcnt_ff;
   logic [W+MCH-1:0] pp;
   assign pp = (W+MCH)'(mag_a) * (W+MCH)'(bsh_ff[MCH-1:0]);
   assign status.mul_done = cmd.mul_step && (mcnt_ff == MCW'(MST - 1));
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff  <= '0;
         bsh_ff  <= MW'(req_value_b[W-1] ? (~req_value_b + W'(1)) : req_value_b);
         mcnt_ff <= '0;
      end else if (cmd.mul_step) begin
         acc_ff  <= acc_ff + (MW'(pp) << (MCH * mcnt_ff));
         bsh_ff  <= bsh_ff >> MCH;
         mcnt_ff <= mcnt_ff + MCW'(1);
      end
   end

   // result formation
   function automatic logic [W-1:0] sat_u(input logic [MW-1:0] m, input logic ng);
      logic [MW-1:0] lim;
      logic [W-1:0]  v;
      lim = ng ? (MW'(VMAX) + MW'(1)) : MW'(VMAX);
      v   = (m > lim) ? lim[W-1:0] : m[W-1:0];
      sat_u = ng ? (~v + W'(1)) : v;
   endfunction

   logic signed [W:0] sum, dif;
   logic [W-1:0] r_add, r_sub, r_cmp, r_val;
   logic [MW-1:0] prod_sh, kval;
   logic cond;
   logic [2*LW-1:0] k;

   assign sum   = {a_ff[W-1], a_ff} + {b_ff[W-1], b_ff};
   assign dif   = {a_ff[W-1], a_ff} - {b_ff[W-1], b_ff};
   assign r_add = (sum[W] != sum[W-1]) ? (sum[W] ? VMIN : VMAX) : sum[W-1:0];
   assign r_sub = (dif[W] != dif[W-1]) ? (dif[W] ? VMIN : VMAX) : dif[W-1:0];
   assign prod_sh = acc_ff >> FRACTION_BITS;
   assign k     = (2*LW)'(cls_a_ff - LW'(1)) * (2*LW)'(lev_b_eff) + (2*LW)'(cls_b_ff);
   assign kval  = MW'(k) << FRACTION_BITS;

   always_comb begin
      case (op_ff)
         eva_pkg::OP_LT:  cond = a_ff < b_ff;
         eva_pkg::OP_GT:  cond = a_ff > b_ff;
         eva_pkg::OP_LE:  cond = a_ff <= b_ff;
         eva_pkg::OP_GE:  cond = a_ff >= b_ff;
         eva_pkg::OP_EQ:  cond = a_ff == b_ff;
         eva_pkg::OP_NE:  cond = a_ff != b_ff;
         eva_pkg::OP_AND: cond = (a_ff != '0) && (b_ff != '0);
         eva_pkg::OP_OR:  cond = (a_ff != '0) || (b_ff != '0);
         default:         cond = 1'b0;
      endcase
      r_cmp = cond ? (pass_ff ? a_ff : ONE) : '0;
      case (op_ff)
         eva_pkg::OP_ADD:   r_val = r_add;
         eva_pkg::OP_SUB:   r_val = r_sub;
         eva_pkg::OP_MUL:   r_val = sat_u(prod_sh, neg);
         eva_pkg::OP_DIV:   r_val = early_ff ? '0 : sat_u(MW'(quo_res_ff), neg);
         eva_pkg::OP_CROSS: r_val = sat_u(kval, 1'b0);
         default: begin
            if (op_ff inside {[eva_pkg::OP_LT:eva_pkg::OP_OR]}) r_val = r_cmp;
            else r_val = '0;
         end
      endcase
   end

   logic signed [W-1:0] res_ff, min_ff, max_ff;
   logic signed [W-1:0] min_base, max_base;
   assign min_base = new_ff ? RST_POS : min_ff;
   assign max_base = new_ff ? RST_NEG : max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= RST_POS;
         max_ff <= RST_NEG;
      end else if (cmd.finish) begin
         min_ff <= ($signed(r_val) < min_base) ? r_val : min_base;
         max_ff <= ($signed(r_val) > max_base) ? r_val : max_base;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.finish) res_ff <= r_val;
   end

   assign rsp_result  = res_ff;
   assign rsp_set_min = min_ff;
   assign rsp_set_max = max_ff;

endmodule
